@@ sv/crsf_rc_frame_receiver_macros.svh @@
// Assertion macros for the CRSF RC frame receiver.
// Included by the controller and datapath; expects clk and rst_n in scope.
`ifndef CRSF_RC_FRAME_RECEIVER_MACROS_SVH
`define CRSF_RC_FRAME_RECEIVER_MACROS_SVH

// Condition holds in the same cycle as the trigger
`define CRSF_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition holds in the cycle after the trigger
`define CRSF_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ sv/crsf_pkg.sv @@
// Shared types, constants and the CRC-8 step for the CRSF RC frame receiver.
// No dependencies; used by crsf_dp, crsf_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package crsf_pkg;

    localparam int MAX_FRAME_LENGTH = 62;
    localparam int PAYLOAD_BYTES    = 22;
    localparam int CHANNELS         = 16;
    localparam int CHAN_BITS        = 11;
    localparam int STORE_BITS       = PAYLOAD_BYTES * 8;

    localparam logic [7:0] CRC_POLY  = 8'hD5;
    localparam logic [7:0] RC_TYPE   = 8'h16;
    localparam logic [6:0] RC_TOTAL  = 7'd26;

    // per-byte outcome reported by the datapath
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_BADLEN = 2'd1;
    localparam logic [1:0] EV_CRCERR = 2'd2;
    localparam logic [1:0] EV_RC     = 2'd3;

    // result kinds on the output stream
    localparam logic [1:0] KIND_CHAN   = 2'd0;
    localparam logic [1:0] KIND_BADLEN = 2'd1;
    localparam logic [1:0] KIND_CRCERR = 2'd2;

    localparam logic [3:0] LAST_CHAN = 4'(CHANNELS - 1);

    typedef struct packed {
        logic step;     // take the request byte
        logic advance;  // drop the channel just delivered
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] evt;
    } dp_status_t;

    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ sv/crsf_dp.sv @@
// Datapath: frame position, CRC, type, payload shift store and frame counters.
// Depends on crsf_pkg and crsf_rc_frame_receiver_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "crsf_rc_frame_receiver_macros.svh"

module crsf_dp
#(
    parameter int MAX_FRAME_LENGTH = crsf_pkg::MAX_FRAME_LENGTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          rx_byte,
    input  wire crsf_pkg::dp_cmd_t   cmd,
    output crsf_pkg::dp_status_t     status,
    output logic [10:0]              channel_value,
    output logic [31:0]              good_frames,
    output logic [31:0]              bad_frames
);
    import crsf_pkg::*;

    logic [6:0]            byte_position_reg, byte_position_next;
    logic [6:0]            frame_total_reg, frame_total_next;
    logic [7:0]            running_crc_reg, running_crc_next;
    logic [7:0]            frame_kind_reg, frame_kind_next;
    logic [STORE_BITS-1:0] store_reg, store_next;
    logic [31:0]           good_count_reg, good_count_next;
    logic [31:0]           bad_count_reg, bad_count_next;

    logic       len_bad;
    logic       in_body;
    logic       in_store;
    logic [1:0] evt;

    assign len_bad  = (rx_byte < 8'd2) || (rx_byte > 8'(MAX_FRAME_LENGTH));
    assign in_body  = ({1'b0, byte_position_reg} + 8'd1) < {1'b0, frame_total_reg};
    assign in_store = (byte_position_reg >= 7'd3) && (byte_position_reg < 7'(PAYLOAD_BYTES + 3));

    always_comb
    begin
        evt = EV_NONE;
        if (byte_position_reg == 7'd1)
        begin
            if (len_bad)
            begin
                evt = EV_BADLEN;
            end
        end
        else if (byte_position_reg != 7'd0 && !in_body)
        begin
            if (rx_byte != running_crc_reg)
            begin
                evt = EV_CRCERR;
            end
            else if (frame_kind_reg == RC_TYPE && frame_total_reg == RC_TOTAL)
            begin
                evt = EV_RC;
            end
        end
    end

    always_comb
    begin
        byte_position_next = byte_position_reg;
        frame_total_next   = frame_total_reg;
        running_crc_next   = running_crc_reg;
        frame_kind_next    = frame_kind_reg;
        store_next         = store_reg;
        good_count_next    = good_count_reg;
        bad_count_next     = bad_count_reg;
        if (cmd.step)
        begin
            if (byte_position_reg == 7'd0)
            begin
                byte_position_next = 7'd1;
            end
            else if (byte_position_reg == 7'd1)
            begin
                if (len_bad)
                begin
                    byte_position_next = 7'd0;
                end
                else
                begin
                    frame_total_next   = rx_byte[6:0] + 7'd2;
                    running_crc_next   = 8'd0;
                    byte_position_next = 7'd2;
                end
            end
            else if (in_body)
            begin
                if (byte_position_reg == 7'd2)
                begin
                    frame_kind_next = rx_byte;
                end
                else if (in_store)
                begin
                    store_next = {rx_byte, store_reg[STORE_BITS-1:8]};
                end
                running_crc_next   = crc_update(running_crc_reg, rx_byte);
                byte_position_next = byte_position_reg + 7'd1;
            end
            else
            begin
                byte_position_next = 7'd0;
            end
            case (evt)
                EV_BADLEN, EV_CRCERR: bad_count_next = bad_count_reg + 32'd1;
                EV_RC:                good_count_next = good_count_reg + 32'd1;
                default:              ;
            endcase
        end
        else if (cmd.advance)
        begin
            store_next = {{CHAN_BITS{1'b0}}, store_reg[STORE_BITS-1:CHAN_BITS]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= 7'd0;
            frame_total_reg   <= 7'd0;
            running_crc_reg   <= 8'd0;
            frame_kind_reg    <= 8'd0;
            good_count_reg    <= 32'd0;
            bad_count_reg     <= 32'd0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            frame_total_reg   <= frame_total_next;
            running_crc_reg   <= running_crc_next;
            frame_kind_reg    <= frame_kind_next;
            good_count_reg    <= good_count_next;
            bad_count_reg     <= bad_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

    assign status.evt    = evt;
    assign channel_value = store_reg[CHAN_BITS-1:0];
    assign good_frames   = good_count_reg;
    assign bad_frames    = bad_count_reg;

    `CRSF_ASSERT_SAME(a_pos_in_frame, byte_position_reg > 7'd2, byte_position_reg < frame_total_reg, "byte position beyond frame end")
    `CRSF_ASSERT_NEXT(a_bad_count, cmd.step && (evt == EV_BADLEN || evt == EV_CRCERR), bad_count_reg == $past(bad_count_reg) + 32'd1, "bad frame not counted")
    `CRSF_ASSERT_NEXT(a_good_hold, !(cmd.step && evt == EV_RC), good_count_reg == $past(good_count_reg), "good count moved without an RC frame")

endmodule

`default_nettype wire

@@ sv/crsf_ctrl.sv @@
// Controller: request handshake, output register and channel burst sequencing.
// Depends on crsf_pkg and crsf_rc_frame_receiver_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "crsf_rc_frame_receiver_macros.svh"

module crsf_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               out_kind,
    output logic [3:0]               out_index,
    output logic                     out_last,
    input  wire crsf_pkg::dp_status_t status,
    output crsf_pkg::dp_cmd_t        cmd
);
    import crsf_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic       state_reg, state_next;
    logic       valid_reg, valid_next;
    logic [1:0] kind_reg, kind_next;
    logic [3:0] index_reg, index_next;

    logic accept;
    logic take;

    assign in_ready = (state_reg == ST_IDLE) && (!valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign take     = valid_reg && out_ready;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        index_next = index_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (status.evt)
                        EV_BADLEN:
                        begin
                            valid_next = 1'b1;
                            kind_next  = KIND_BADLEN;
                            index_next = 4'd0;
                        end
                        EV_CRCERR:
                        begin
                            valid_next = 1'b1;
                            kind_next  = KIND_CRCERR;
                            index_next = 4'd0;
                        end
                        EV_RC:
                        begin
                            valid_next = 1'b1;
                            kind_next  = KIND_CHAN;
                            index_next = 4'd0;
                            state_next = ST_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (take)
                begin
                    if (index_reg == LAST_CHAN)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        index_next = index_reg + 4'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            kind_reg  <= KIND_CHAN;
            index_reg <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            kind_reg  <= kind_next;
            index_reg <= index_next;
        end
    end

    assign cmd = '{step: accept, advance: take && (state_reg == ST_EMIT)};

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_index = index_reg;
    assign out_last  = (kind_reg != KIND_CHAN) || (index_reg == LAST_CHAN);

    `CRSF_ASSERT_SAME(a_emit_valid, state_reg == ST_EMIT, valid_reg && !in_ready, "burst without a pending channel")
    `CRSF_ASSERT_SAME(a_err_index, valid_reg && kind_reg != KIND_CHAN, index_reg == 4'd0 && state_reg == ST_IDLE, "error result with channel index")
    `CRSF_ASSERT_NEXT(a_rc_start, accept && status.evt == EV_RC, state_reg == ST_EMIT && index_reg == 4'd0 && kind_reg == KIND_CHAN, "RC frame did not start a burst")

endmodule

`default_nettype wire

@@ sv/crsf_rc_frame_receiver.sv @@
// CRSF RC frame receiver top level: joins controller and datapath to the streams.
// Depends on crsf_pkg, crsf_ctrl and crsf_dp.
//
// Usage:
//   s_axis carries one received serial byte per request in tdata[7:0].
//   m_axis carries results: tuser is the result kind (0 channel, 1 bad length,
//   2 checksum mismatch), tdata packs channel index, channel value and both
//   frame counters, tlast marks the final result caused by one byte.
//   A byte that gives one result puts it on m_axis the next cycle; the next
//   byte is taken in the same cycle that result is accepted downstream. A
//   byte closing a good RC-channels frame gives sixteen channel results back
//   to back while m_axis tready stays high; s_axis tready stays low
//   through the cycle in which the last one is taken. The 176-bit payload
//   shift store shifts 11 bits per delivered channel and supplies the
//   values of those sixteen channel results.
//   Reset clears the parser position, CRC, counters and any pending result.
//   A low m_axis tready holds the current result and stops the input side
//   once a result is pending and not being taken.
`timescale 1ns / 1ps
`default_nettype none

module crsf_rc_frame_receiver
#(
    parameter int MAX_FRAME_LENGTH = crsf_pkg::MAX_FRAME_LENGTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [3:0] channel_index, [14:4] channel_value, [46:15] good_frames,
    // [78:47] bad_frames, [79] zero
    output logic [79:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    output logic [1:0]       m_axis_tuser    // [1:0] result_kind
);
    import crsf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [3:0]  out_index;
    logic [1:0]  out_kind;
    logic [10:0] chan_value;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
    logic [10:0] value_field;

    crsf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (out_kind),
        .out_index (out_index),
        .out_last  (m_axis_tlast),
        .status    (status),
        .cmd       (cmd)
    );

    crsf_dp
    #(
        .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_byte       (s_axis_tdata),
        .cmd           (cmd),
        .status        (status),
        .channel_value (chan_value),
        .good_frames   (good_frames),
        .bad_frames    (bad_frames)
    );

    assign value_field  = (out_kind == KIND_CHAN) ? chan_value : 11'd0;
    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {1'b0, bad_frames, good_frames, value_field, out_index};

endmodule

`default_nettype wire
